### sv/assert_macros.svh
// Assertion macros shared by the line pair intersection RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is high
`define LPI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset
`define LPI_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LPI_ASSERT(lbl, clk, rst, prop, msg)

`define LPI_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

### sv/lpi_pkg.sv
// Shared constants and types of the line pair intersection block.
// No dependencies; used by the interfaces and every module.
package lpi_pkg;

   localparam int IN_FRAC_BITS   = 4;
   localparam int TOL_WIDTH      = 34;
   localparam int POINT_WIDTH    = 32;
   // One quotient bit beyond the point width; rounding is judged from the remainder
   localparam int QUOT_BITS      = POINT_WIDTH + 1;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 4;

   // Register index, taken from the top address bit (registers sit at 8*i)
   localparam logic CSR_IDX_ZERO_TOL = 1'b0;

   // Relation codes
   localparam logic [1:0] REL_PARALLEL = 2'd0;
   localparam logic [1:0] REL_SAME     = 2'd1;
   localparam logic [1:0] REL_CROSS    = 2'd2;

   typedef struct packed {
      logic [1:0] relation;
      logic       neg_x;
      logic       neg_y;
      logic       ovf_x;
      logic       ovf_y;
   } lpi_ctl_type;

endpackage

### sv/lpi_channels.sv
// Valid/ready channel interfaces for line pair items and crossing results.
// Depends on lpi_pkg.
interface lpi_req_if import lpi_pkg::*; #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] p1_x;
   logic signed [COORD_WIDTH-1:0] p1_y;
   logic signed [COORD_WIDTH-1:0] p2_x;
   logic signed [COORD_WIDTH-1:0] p2_y;
   logic signed [COORD_WIDTH-1:0] p3_x;
   logic signed [COORD_WIDTH-1:0] p3_y;
   logic signed [COORD_WIDTH-1:0] p4_x;
   logic signed [COORD_WIDTH-1:0] p4_y;

   modport source (output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
                   input ready);
   modport sink (input valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
                 output ready);
endinterface

interface lpi_rsp_if import lpi_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    relation;
   logic signed [POINT_WIDTH-1:0] point_x;
   logic signed [POINT_WIDTH-1:0] point_y;
   logic                          overflow;

   modport source (output valid, relation, point_x, point_y, overflow, input ready);
   modport sink (input valid, relation, point_x, point_y, overflow, output ready);
endinterface

### sv/lpi_front.sv
// Front pipeline: differences, cross products, relation test and the
// scaled numerators and divisor for the divider chain. Depends on lpi_pkg.
module lpi_front import lpi_pkg::*; #(
   parameter int COORD_WIDTH   = 16,
   parameter int OUT_FRAC_BITS = 8,
   parameter int REM_WIDTH     = 73,
   parameter int DIV_WIDTH     = 39
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] p1_x,
   input  logic signed [COORD_WIDTH-1:0] p1_y,
   input  logic signed [COORD_WIDTH-1:0] p2_x,
   input  logic signed [COORD_WIDTH-1:0] p2_y,
   input  logic signed [COORD_WIDTH-1:0] p3_x,
   input  logic signed [COORD_WIDTH-1:0] p3_y,
   input  logic signed [COORD_WIDTH-1:0] p4_x,
   input  logic signed [COORD_WIDTH-1:0] p4_y,
   input  logic [TOL_WIDTH-1:0]          tol,
   output logic                          out_valid,
   input  logic                          out_ready,
   output lpi_ctl_type                   out_ctl,
   output logic [REM_WIDTH-1:0]          out_rem_x,
   output logic [REM_WIDTH-1:0]          out_rem_y,
   output logic [DIV_WIDTH-1:0]          out_div
);

   localparam int DW   = COORD_WIDTH + 1;
   localparam int PW   = 2 * DW;
   localparam int XW   = PW + 1;
   localparam int TW   = COORD_WIDTH + XW;
   localparam int MW   = XW + DW;
   localparam int SW   = MW + 1;
   localparam int CMPW = (XW > TOL_WIDTH) ? XW : TOL_WIDTH;
   localparam int NS   = 7;

   // stage valids and the ready ripple
   logic [NS:1]   v_ff, v_in;
   logic [NS+1:1] rdy;

   always_comb begin
      rdy[NS+1] = out_ready;
      for (int k = NS; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[1] = rdy[1] ? in_valid : v_ff[1];
      for (int k = 2; k <= NS; k++) begin
         v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = rdy[1];
   assign out_valid = v_ff[NS];

   // stage 1: direction and offset vectors
   logic signed [DW-1:0] s1_d1x_ff, s1_d1y_ff, s1_d2x_ff, s1_d2y_ff;
   logic signed [DW-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic signed [DW-1:0] s1_d1x_in, s1_d1y_in, s1_d2x_in, s1_d2y_in;
   logic signed [DW-1:0] s1_ax_in, s1_ay_in, s1_bx_in, s1_by_in;
   logic signed [COORD_WIDTH-1:0] s1_x3_ff, s1_y3_ff;

   always_comb begin
      s1_d1x_in = DW'(p2_x) - DW'(p1_x);
      s1_d1y_in = DW'(p2_y) - DW'(p1_y);
      s1_d2x_in = DW'(p4_x) - DW'(p3_x);
      s1_d2y_in = DW'(p4_y) - DW'(p3_y);
      s1_ax_in  = DW'(p3_x) - DW'(p1_x);
      s1_ay_in  = DW'(p3_y) - DW'(p1_y);
      s1_bx_in  = DW'(p4_x) - DW'(p1_x);
      s1_by_in  = DW'(p4_y) - DW'(p1_y);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_d1x_ff <= s1_d1x_in;
         s1_d1y_ff <= s1_d1y_in;
         s1_d2x_ff <= s1_d2x_in;
         s1_d2y_ff <= s1_d2y_in;
         s1_ax_ff  <= s1_ax_in;
         s1_ay_ff  <= s1_ay_in;
         s1_bx_ff  <= s1_bx_in;
         s1_by_ff  <= s1_by_in;
         s1_x3_ff  <= p3_x;
         s1_y3_ff  <= p3_y;
      end
   end

   // stage 2: the six partial products of the three cross products
   logic signed [PW-1:0] s2_pa_ff, s2_pb_ff, s2_pc_ff, s2_pd_ff, s2_pe_ff, s2_pf_ff;
   logic signed [PW-1:0] s2_pa_in, s2_pb_in, s2_pc_in, s2_pd_in, s2_pe_in, s2_pf_in;
   logic signed [DW-1:0] s2_d2x_ff, s2_d2y_ff;
   logic signed [COORD_WIDTH-1:0] s2_x3_ff, s2_y3_ff;

   always_comb begin
      s2_pa_in = PW'(s1_d1x_ff) * PW'(s1_d2y_ff);
      s2_pb_in = PW'(s1_d2x_ff) * PW'(s1_d1y_ff);
      s2_pc_in = PW'(s1_bx_ff) * PW'(s1_ay_ff);
      s2_pd_in = PW'(s1_ax_ff) * PW'(s1_by_ff);
      s2_pe_in = PW'(s1_ax_ff) * PW'(s1_d1y_ff);
      s2_pf_in = PW'(s1_d1x_ff) * PW'(s1_ay_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_pa_ff  <= s2_pa_in;
         s2_pb_ff  <= s2_pb_in;
         s2_pc_ff  <= s2_pc_in;
         s2_pd_ff  <= s2_pd_in;
         s2_pe_ff  <= s2_pe_in;
         s2_pf_ff  <= s2_pf_in;
         s2_d2x_ff <= s1_d2x_ff;
         s2_d2y_ff <= s1_d2y_ff;
         s2_x3_ff  <= s1_x3_ff;
         s2_y3_ff  <= s1_y3_ff;
      end
   end

   // stage 3: denominator, collinearity and numerator cross products
   logic signed [XW-1:0] s3_den_ff, s3_col_ff, s3_num_ff;
   logic signed [XW-1:0] s3_den_in, s3_col_in, s3_num_in;
   logic signed [DW-1:0] s3_d2x_ff, s3_d2y_ff;
   logic signed [COORD_WIDTH-1:0] s3_x3_ff, s3_y3_ff;

   always_comb begin
      s3_den_in = XW'(s2_pa_ff) - XW'(s2_pb_ff);
      s3_col_in = XW'(s2_pc_ff) - XW'(s2_pd_ff);
      s3_num_in = XW'(s2_pe_ff) - XW'(s2_pf_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_den_ff <= s3_den_in;
         s3_col_ff <= s3_col_in;
         s3_num_ff <= s3_num_in;
         s3_d2x_ff <= s2_d2x_ff;
         s3_d2y_ff <= s2_d2y_ff;
         s3_x3_ff  <= s2_x3_ff;
         s3_y3_ff  <= s2_y3_ff;
      end
   end

   // stage 4: tolerance tests and the numerator terms
   logic [XW-1:0]        s4_den_abs_ff, s4_den_abs_in, col_abs;
   logic                 s4_den_neg_ff;
   lpi_ctl_type          s4_ctl_ff, s4_ctl_in;
   logic signed [TW-1:0] s4_tx_ff, s4_ty_ff, s4_tx_in, s4_ty_in;
   logic signed [MW-1:0] s4_mx_ff, s4_my_ff, s4_mx_in, s4_my_in;

   always_comb begin
      s4_den_abs_in = s3_den_ff[XW-1] ? XW'(-s3_den_ff) : XW'(s3_den_ff);
      col_abs       = s3_col_ff[XW-1] ? XW'(-s3_col_ff) : XW'(s3_col_ff);
      s4_ctl_in     = '0;
      if (CMPW'(s4_den_abs_in) > CMPW'(tol)) begin
         s4_ctl_in.relation = REL_CROSS;
      end else if (CMPW'(col_abs) <= CMPW'(tol)) begin
         s4_ctl_in.relation = REL_SAME;
      end else begin
         s4_ctl_in.relation = REL_PARALLEL;
      end
      s4_tx_in = TW'(s3_x3_ff) * TW'(s3_den_ff);
      s4_ty_in = TW'(s3_y3_ff) * TW'(s3_den_ff);
      s4_mx_in = MW'(s3_num_ff) * MW'(s3_d2x_ff);
      s4_my_in = MW'(s3_num_ff) * MW'(s3_d2y_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_den_abs_ff <= s4_den_abs_in;
         s4_den_neg_ff <= s3_den_ff[XW-1];
         s4_ctl_ff     <= s4_ctl_in;
         s4_tx_ff      <= s4_tx_in;
         s4_ty_ff      <= s4_ty_in;
         s4_mx_ff      <= s4_mx_in;
         s4_my_ff      <= s4_my_in;
      end
   end

   // stage 5: unscaled crossing numerators
   logic signed [SW-1:0] s5_sx_ff, s5_sy_ff, s5_sx_in, s5_sy_in;
   logic [XW-1:0]        s5_den_abs_ff;
   logic                 s5_den_neg_ff;
   lpi_ctl_type          s5_ctl_ff;

   always_comb begin
      s5_sx_in = SW'(s4_tx_ff) + SW'(s4_mx_ff);
      s5_sy_in = SW'(s4_ty_ff) + SW'(s4_my_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_sx_ff      <= s5_sx_in;
         s5_sy_ff      <= s5_sy_in;
         s5_den_abs_ff <= s4_den_abs_ff;
         s5_den_neg_ff <= s4_den_neg_ff;
         s5_ctl_ff     <= s4_ctl_ff;
      end
   end

   // stage 6: magnitudes, result signs and output scaling
   logic [SW-1:0]        sx_abs, sy_abs;
   logic [REM_WIDTH-1:0] s6_un_x_ff, s6_un_y_ff, s6_un_x_in, s6_un_y_in;
   logic [DIV_WIDTH-1:0] s6_ud_ff, s6_ud_in;
   lpi_ctl_type          s6_ctl_ff, s6_ctl_in;

   always_comb begin
      sx_abs     = s5_sx_ff[SW-1] ? SW'(-s5_sx_ff) : SW'(s5_sx_ff);
      sy_abs     = s5_sy_ff[SW-1] ? SW'(-s5_sy_ff) : SW'(s5_sy_ff);
      s6_un_x_in = REM_WIDTH'(sx_abs) << OUT_FRAC_BITS;
      s6_un_y_in = REM_WIDTH'(sy_abs) << OUT_FRAC_BITS;
      s6_ud_in   = DIV_WIDTH'(s5_den_abs_ff) << IN_FRAC_BITS;
      s6_ctl_in       = s5_ctl_ff;
      s6_ctl_in.neg_x = s5_sx_ff[SW-1] ^ s5_den_neg_ff;
      s6_ctl_in.neg_y = s5_sy_ff[SW-1] ^ s5_den_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_un_x_ff <= s6_un_x_in;
         s6_un_y_ff <= s6_un_y_in;
         s6_ud_ff   <= s6_ud_in;
         s6_ctl_ff  <= s6_ctl_in;
      end
   end

   // stage 7: flag quotients too large for the divider chain
   logic [REM_WIDTH-1:0] ud_top;
   lpi_ctl_type          s7_ctl_ff, s7_ctl_in;
   logic [REM_WIDTH-1:0] s7_un_x_ff, s7_un_y_ff;
   logic [DIV_WIDTH-1:0] s7_ud_ff;

   always_comb begin
      ud_top          = REM_WIDTH'(s6_ud_ff) << QUOT_BITS;
      s7_ctl_in       = s6_ctl_ff;
      s7_ctl_in.ovf_x = s6_un_x_ff >= ud_top;
      s7_ctl_in.ovf_y = s6_un_y_ff >= ud_top;
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         s7_ctl_ff  <= s7_ctl_in;
         s7_un_x_ff <= s6_un_x_ff;
         s7_un_y_ff <= s6_un_y_ff;
         s7_ud_ff   <= s6_ud_ff;
      end
   end

   assign out_ctl   = s7_ctl_ff;
   assign out_rem_x = s7_un_x_ff;
   assign out_rem_y = s7_un_y_ff;
   assign out_div   = s7_ud_ff;

endmodule

### sv/lpi_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit for
// both coordinates and hands the item on. Depends on lpi_pkg.
module lpi_div_cell import lpi_pkg::*; #(
   parameter int REM_WIDTH = 73,
   parameter int DIV_WIDTH = 39,
   parameter int SHIFT     = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lpi_ctl_type          in_ctl,
   input  logic [REM_WIDTH-1:0] in_rem_x,
   input  logic [REM_WIDTH-1:0] in_rem_y,
   input  logic [DIV_WIDTH-1:0] in_div,
   input  logic [QUOT_BITS-1:0] in_quo_x,
   input  logic [QUOT_BITS-1:0] in_quo_y,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lpi_ctl_type          out_ctl,
   output logic [REM_WIDTH-1:0] out_rem_x,
   output logic [REM_WIDTH-1:0] out_rem_y,
   output logic [DIV_WIDTH-1:0] out_div,
   output logic [QUOT_BITS-1:0] out_quo_x,
   output logic [QUOT_BITS-1:0] out_quo_y
);

   localparam logic [QUOT_BITS-1:0] QBIT = QUOT_BITS'(1) << SHIFT;

   logic                 valid_ff;
   lpi_ctl_type          ctl_ff;
   logic [REM_WIDTH-1:0] rem_x_ff, rem_y_ff, rem_x_in, rem_y_in, div_sh;
   logic [DIV_WIDTH-1:0] div_ff;
   logic [QUOT_BITS-1:0] quo_x_ff, quo_y_ff, quo_x_in, quo_y_in;

   assign in_ready = !valid_ff || out_ready;

   // trial subtract of the divisor at this bit weight
   always_comb begin
      div_sh   = REM_WIDTH'(in_div) << SHIFT;
      rem_x_in = in_rem_x;
      quo_x_in = in_quo_x;
      rem_y_in = in_rem_y;
      quo_y_in = in_quo_y;
      if (in_rem_x >= div_sh) begin
         rem_x_in = in_rem_x - div_sh;
         quo_x_in = in_quo_x | QBIT;
      end
      if (in_rem_y >= div_sh) begin
         rem_y_in = in_rem_y - div_sh;
         quo_y_in = in_quo_y | QBIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctl_ff   <= in_ctl;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         div_ff   <= in_div;
         quo_x_ff <= quo_x_in;
         quo_y_ff <= quo_y_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_div   = div_ff;
   assign out_quo_x = quo_x_ff;
   assign out_quo_y = quo_y_ff;

endmodule

### sv/lpi_back.sv
// Back end: rounds the quotients, applies sign and saturation and holds
// the result item in the output register. Depends on lpi_pkg.
module lpi_back import lpi_pkg::*; #(
   parameter int REM_WIDTH = 73,
   parameter int DIV_WIDTH = 39
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  lpi_ctl_type                   in_ctl,
   input  logic [REM_WIDTH-1:0]          in_rem_x,
   input  logic [REM_WIDTH-1:0]          in_rem_y,
   input  logic [DIV_WIDTH-1:0]          in_div,
   input  logic [QUOT_BITS-1:0]          in_quo_x,
   input  logic [QUOT_BITS-1:0]          in_quo_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [1:0]                    out_relation,
   output logic signed [POINT_WIDTH-1:0] out_point_x,
   output logic signed [POINT_WIDTH-1:0] out_point_y,
   output logic                          out_overflow
);

   localparam int QW = QUOT_BITS + 1;
   localparam logic [QW-1:0] NEG_LIM = QW'(1) << (POINT_WIDTH - 1);
   localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);
   localparam logic [POINT_WIDTH-1:0] SAT_NEG = POINT_WIDTH'(1) << (POINT_WIDTH - 1);
   localparam logic [POINT_WIDTH-1:0] SAT_POS = ~SAT_NEG;

   logic       a_valid_ff, b_valid_ff, a_ready;
   assign in_ready = !a_valid_ff || a_ready;
   assign a_ready  = !b_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (a_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   // stage A: round to nearest, ties away from zero
   logic [QW-1:0] a_qr_x_ff, a_qr_y_ff, a_qr_x_in, a_qr_y_in;
   lpi_ctl_type   a_ctl_ff;
   logic          rnd_x, rnd_y;

   always_comb begin
      rnd_x     = ((REM_WIDTH + 1)'(in_rem_x) << 1) >= (REM_WIDTH + 1)'(in_div);
      rnd_y     = ((REM_WIDTH + 1)'(in_rem_y) << 1) >= (REM_WIDTH + 1)'(in_div);
      a_qr_x_in = QW'(in_quo_x) + QW'(rnd_x);
      a_qr_y_in = QW'(in_quo_y) + QW'(rnd_y);
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         a_qr_x_ff <= a_qr_x_in;
         a_qr_y_ff <= a_qr_y_in;
         a_ctl_ff  <= in_ctl;
      end
   end

   // stage B: sign, saturate, zero the point when there is no crossing
   logic                   sat_x, sat_y;
   logic [1:0]             b_rel_ff;
   logic [POINT_WIDTH-1:0] b_px_ff, b_py_ff, b_px_in, b_py_in;
   logic                   b_ovf_ff, b_ovf_in;

   always_comb begin
      sat_x = a_ctl_ff.ovf_x || (a_ctl_ff.neg_x ? (a_qr_x_ff > NEG_LIM)
                                                : (a_qr_x_ff > POS_LIM));
      sat_y = a_ctl_ff.ovf_y || (a_ctl_ff.neg_y ? (a_qr_y_ff > NEG_LIM)
                                                : (a_qr_y_ff > POS_LIM));
      if (sat_x) begin
         b_px_in = a_ctl_ff.neg_x ? SAT_NEG : SAT_POS;
      end else begin
         b_px_in = a_ctl_ff.neg_x ? POINT_WIDTH'(-a_qr_x_ff) : POINT_WIDTH'(a_qr_x_ff);
      end
      if (sat_y) begin
         b_py_in = a_ctl_ff.neg_y ? SAT_NEG : SAT_POS;
      end else begin
         b_py_in = a_ctl_ff.neg_y ? POINT_WIDTH'(-a_qr_y_ff) : POINT_WIDTH'(a_qr_y_ff);
      end
      b_ovf_in = sat_x || sat_y;
      if (a_ctl_ff.relation != REL_CROSS) begin
         b_px_in  = '0;
         b_py_in  = '0;
         b_ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         b_rel_ff <= a_ctl_ff.relation;
         b_px_ff  <= b_px_in;
         b_py_ff  <= b_py_in;
         b_ovf_ff <= b_ovf_in;
      end
   end

   assign out_valid    = b_valid_ff;
   assign out_relation = b_rel_ff;
   assign out_point_x  = b_px_ff;
   assign out_point_y  = b_py_ff;
   assign out_overflow = b_ovf_ff;

endmodule

### sv/line_pair_intersection.sv
// Line pair intersection top level: tolerance register, front pipeline,
// divider cell chain and output stage. Depends on lpi_pkg, lpi_channels,
// lpi_front, lpi_div_cell, lpi_back and assert_macros.svh.
//
//   port     | way | moves
//   ---------+-----+-----------------------------------------------
//   req_ch   | in  | item: two lines, four points in Q12.4
//   rsp_ch   | out | item: relation, crossing point in Q24.8, overflow
//   apb      | in  | zero_tolerance register at byte address 0
//
// One item enters per cycle while no result stalls; each passes 42 register
// stages: 7 front stages, 33 divider cells (one quotient bit each) and 2
// rounding and saturation stages. The divider chain sets the latency.
// Reset is synchronous: it empties every stage and sets the tolerance to 0.
// A stalled result holds every stage behind it; ready ripples back stage by
// stage, so bubbles close up and input is taken while any stage is free.
`include "assert_macros.svh"
module line_pair_intersection import lpi_pkg::*; #(
   parameter int COORD_WIDTH   = 16,
   parameter int OUT_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   lpi_req_if.sink                   req_ch,
   lpi_rsp_if.source                 rsp_ch,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int DW  = COORD_WIDTH + 1;
   localparam int XW  = 2 * DW + 1;
   localparam int NW  = XW + DW + 1 + OUT_FRAC_BITS;
   localparam int UDW = XW + IN_FRAC_BITS;
   localparam int RW  = (NW > UDW + QUOT_BITS + 1) ? NW : UDW + QUOT_BITS + 1;

   // tolerance register
   logic [TOL_WIDTH-1:0] tol_ff;
   logic                 tol_we;

   assign pready = 1'b1;
   assign tol_we = psel && penable && pwrite &&
                   (paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_ZERO_TOL);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (tol_we) begin
         tol_ff <= pwdata[TOL_WIDTH-1:0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_ZERO_TOL) ?
                   CSR_DATA_WIDTH'(tol_ff) : '0;

   // links between front, cells and back
   logic                 c_valid [QUOT_BITS+1];
   logic                 c_ready [QUOT_BITS+1];
   lpi_ctl_type          c_ctl   [QUOT_BITS+1];
   logic [RW-1:0]        c_rem_x [QUOT_BITS+1];
   logic [RW-1:0]        c_rem_y [QUOT_BITS+1];
   logic [UDW-1:0]       c_div   [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] c_quo_x [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] c_quo_y [QUOT_BITS+1];

   lpi_front #(
      .COORD_WIDTH   (COORD_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .REM_WIDTH     (RW),
      .DIV_WIDTH     (UDW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .p1_x      (req_ch.p1_x),
      .p1_y      (req_ch.p1_y),
      .p2_x      (req_ch.p2_x),
      .p2_y      (req_ch.p2_y),
      .p3_x      (req_ch.p3_x),
      .p3_y      (req_ch.p3_y),
      .p4_x      (req_ch.p4_x),
      .p4_y      (req_ch.p4_y),
      .tol       (tol_ff),
      .out_valid (c_valid[0]),
      .out_ready (c_ready[0]),
      .out_ctl   (c_ctl[0]),
      .out_rem_x (c_rem_x[0]),
      .out_rem_y (c_rem_y[0]),
      .out_div   (c_div[0])
   );

   assign c_quo_x[0] = '0;
   assign c_quo_y[0] = '0;

   // divider chain, most significant quotient bit first
   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
      lpi_div_cell #(
         .REM_WIDTH (RW),
         .DIV_WIDTH (UDW),
         .SHIFT     (QUOT_BITS - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[k]),
         .in_ready  (c_ready[k]),
         .in_ctl    (c_ctl[k]),
         .in_rem_x  (c_rem_x[k]),
         .in_rem_y  (c_rem_y[k]),
         .in_div    (c_div[k]),
         .in_quo_x  (c_quo_x[k]),
         .in_quo_y  (c_quo_y[k]),
         .out_valid (c_valid[k+1]),
         .out_ready (c_ready[k+1]),
         .out_ctl   (c_ctl[k+1]),
         .out_rem_x (c_rem_x[k+1]),
         .out_rem_y (c_rem_y[k+1]),
         .out_div   (c_div[k+1]),
         .out_quo_x (c_quo_x[k+1]),
         .out_quo_y (c_quo_y[k+1])
      );
   end

   lpi_back #(
      .REM_WIDTH (RW),
      .DIV_WIDTH (UDW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (c_valid[QUOT_BITS]),
      .in_ready     (c_ready[QUOT_BITS]),
      .in_ctl       (c_ctl[QUOT_BITS]),
      .in_rem_x     (c_rem_x[QUOT_BITS]),
      .in_rem_y     (c_rem_y[QUOT_BITS]),
      .in_div       (c_div[QUOT_BITS]),
      .in_quo_x     (c_quo_x[QUOT_BITS]),
      .in_quo_y     (c_quo_y[QUOT_BITS]),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_relation (rsp_ch.relation),
      .out_point_x  (rsp_ch.point_x),
      .out_point_y  (rsp_ch.point_y),
      .out_overflow (rsp_ch.overflow)
   );

   // checks
   `LPI_ASSERT(a_no_point, clock, reset,
      rsp_ch.valid && rsp_ch.relation != REL_CROSS |->
         rsp_ch.point_x == '0 && rsp_ch.point_y == '0 && !rsp_ch.overflow,
      "point or overflow set without a crossing")
   `LPI_ASSERT(a_ovf_sat, clock, reset,
      rsp_ch.valid && rsp_ch.overflow |->
         rsp_ch.point_x == 32'sh7fffffff || rsp_ch.point_x == 32'sh80000000 ||
         rsp_ch.point_y == 32'sh7fffffff || rsp_ch.point_y == 32'sh80000000,
      "overflow without a saturated coordinate")
   `LPI_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_ch.valid, "result item present after reset")

endmodule
